### sv/rgbwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbwf_pkg;

  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 8;
  localparam int COUNT_W  = 16;
  localparam int TICK_W   = 10;
  localparam int PROD_W   = 24;
  localparam int NUM_CH   = 4;
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int REG_IW   = 3;

  localparam logic [LEVEL_W-1:0] CEIL_RED_RST   = 8'd150;
  localparam logic [LEVEL_W-1:0] CEIL_GREEN_RST = 8'd100;
  localparam logic [LEVEL_W-1:0] CEIL_BLUE_RST  = 8'd150;
  localparam logic [LEVEL_W-1:0] CEIL_WHITE_RST = 8'd100;
  localparam logic [COUNT_W-1:0] PERIOD_RST     = 16'd50000;
  localparam logic [TICK_W-1:0]  TICK_RST       = 10'd33;

  localparam logic [REG_IW-1:0] REG_CEIL_RED   = 3'd0;
  localparam logic [REG_IW-1:0] REG_CEIL_GREEN = 3'd1;
  localparam logic [REG_IW-1:0] REG_CEIL_BLUE  = 3'd2;
  localparam logic [REG_IW-1:0] REG_CEIL_WHITE = 3'd3;
  localparam logic [REG_IW-1:0] REG_PWM_PERIOD = 3'd4;
  localparam logic [REG_IW-1:0] REG_TICK_MS    = 3'd5;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_DIRECT = 2'd2;

  localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

  // controller step counts
  localparam logic [CNT_W-1:0] DIV_LAST     = CNT_W'(TIME_W - 1);
  localparam logic [CNT_W-1:0] MV_INIT_CNT  = 5'd0;
  localparam logic [CNT_W-1:0] MV_APPLY_CNT = CNT_W'(LEVEL_W + 1);
  localparam logic [CNT_W-1:0] PH_SEL       = 5'd0;
  localparam logic [CNT_W-1:0] PH_MUL_SQ    = 5'd1;
  localparam logic [CNT_W-1:0] PH_DIV_SQ    = 5'd2;
  localparam logic [CNT_W-1:0] PH_MUL_CEIL  = 5'd3;
  localparam logic [CNT_W-1:0] PH_DIV_CEIL  = 5'd4;
  localparam logic [CNT_W-1:0] PH_MUL_PER   = 5'd5;
  localparam logic [CNT_W-1:0] PH_WRITE     = 5'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [LEVEL_W-1:0] target_red;
    logic [LEVEL_W-1:0] target_green;
    logic [LEVEL_W-1:0] target_blue;
    logic [LEVEL_W-1:0] target_white;
    logic [TIME_W-1:0]  fade_time_ms;
    logic [1:0]         direct_channel;
    logic [15:0]        direct_duty;
  } req_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] compare_red;
    logic [COUNT_W-1:0] compare_green;
    logic [COUNT_W-1:0] compare_blue;
    logic [COUNT_W-1:0] compare_white;
    logic [NUM_CH-1:0]  updated_mask;
    logic               fading;
    logic [TIME_W-1:0]  remaining_ms;
  } rsp_item_t;

  typedef struct packed {
    logic [NUM_CH-1:0][LEVEL_W-1:0] ceiling;
    logic [COUNT_W-1:0]             pwm_period;
    logic [TICK_W-1:0]              tick_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SDIV,
    ST_MDIV,
    ST_SUB,
    ST_DUTY,
    ST_GAMMA,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SNAP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MV_INIT,
    OP_MV_STEP,
    OP_MV_APPLY,
    OP_SUB,
    OP_SEL_LEVEL,
    OP_SEL_DUTY,
    OP_MUL_SQ,
    OP_DIV_SQ,
    OP_MUL_CEIL,
    OP_DIV_CEIL,
    OP_MUL_PER,
    OP_DIV_WRITE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       time_zero;
    logic       snap;
    logic [1:0] direct_ch;
  } dp_stat_t;

  // floor(n / 255) for n below 255 * 65536: estimate n*257 >> 16, one correction
  function automatic logic [COUNT_W-1:0] div255(input logic [PROD_W-1:0] n);
    logic [32:0] t;
    logic [16:0] q;
    logic [25:0] qm;
    logic [25:0] r;
    t  = {9'b0, n} + {1'b0, n, 8'b0};
    q  = t[32:16];
    qm = {1'b0, q, 8'b0} - {9'b0, q};
    r  = {2'b0, n} - qm;
    if (r >= 26'd255) begin
      q = q + 17'd1;
    end
    return q[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/rgbw_fade_gamma_pwm.sv
`timescale 1ns / 1ps
`default_nettype none

// accept to result valid: start, idle tick, unused cmd go from decode to output; direct
// scales its clamped duty by the period; a snapping tick runs a gamma/scale chain per channel;
// a stepping tick: 32-step restoring time divider, 8-step divider per channel, then the chain
// one item in flight: the next item is taken the cycle after its result is registered
// reset: synchronous, active high; levels, goals, time and counts clear, registers take defaults
module rgbw_fade_gamma_pwm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire rgbwf_pkg::req_item_t         req_item,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output rgbwf_pkg::rsp_item_t              rsp_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbwf_pkg::APB_AW-1:0] paddr,
  input  wire logic [rgbwf_pkg::APB_DW-1:0] pwdata,
  output logic      [rgbwf_pkg::APB_DW-1:0] prdata,
  output logic                              pready
);
  import rgbwf_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t stat;

  rgbwf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .dp_cmd    (dp_cmd)
  );

  rgbwf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_item (req_item),
    .cmd      (dp_cmd),
    .stat     (stat),
    .rsp_item (rsp_item)
  );

endmodule

`default_nettype wire

### sv/rgbwf_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbwf_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbwf_pkg::APB_AW-1:0] paddr,
  input  wire logic [rgbwf_pkg::APB_DW-1:0] pwdata,
  output logic      [rgbwf_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  output rgbwf_pkg::cfg_t                   cfg
);
  import rgbwf_pkg::*;

  logic [REG_IW-1:0] idx;
  logic              wr;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ceiling[0] <= CEIL_RED_RST;
      cfg.ceiling[1] <= CEIL_GREEN_RST;
      cfg.ceiling[2] <= CEIL_BLUE_RST;
      cfg.ceiling[3] <= CEIL_WHITE_RST;
      cfg.pwm_period <= PERIOD_RST;
      cfg.tick_ms    <= TICK_RST;
    end else if (wr) begin
      case (idx)
        REG_CEIL_RED:   cfg.ceiling[0] <= pwdata[LEVEL_W-1:0];
        REG_CEIL_GREEN: cfg.ceiling[1] <= pwdata[LEVEL_W-1:0];
        REG_CEIL_BLUE:  cfg.ceiling[2] <= pwdata[LEVEL_W-1:0];
        REG_CEIL_WHITE: cfg.ceiling[3] <= pwdata[LEVEL_W-1:0];
        REG_PWM_PERIOD: cfg.pwm_period <= pwdata[COUNT_W-1:0];
        REG_TICK_MS:    cfg.tick_ms    <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CEIL_RED:   prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg.ceiling[0]};
      REG_CEIL_GREEN: prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg.ceiling[1]};
      REG_CEIL_BLUE:  prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg.ceiling[2]};
      REG_CEIL_WHITE: prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg.ceiling[3]};
      REG_PWM_PERIOD: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg.pwm_period};
      REG_TICK_MS:    prdata = {{(APB_DW-TICK_W){1'b0}}, cfg.tick_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/rgbwf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbwf_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rgbwf_pkg::cfg_t      cfg,
  input  wire rgbwf_pkg::req_item_t req_item,
  input  wire rgbwf_pkg::dp_cmd_t   cmd,
  output rgbwf_pkg::dp_stat_t      stat,
  output rgbwf_pkg::rsp_item_t     rsp_item
);
  import rgbwf_pkg::*;

  req_item_t                   item;
  logic [LEVEL_W-1:0]          level_now  [NUM_CH];
  logic [LEVEL_W-1:0]          level_goal [NUM_CH];
  logic [TIME_W-1:0]           time_left;
  logic [COUNT_W-1:0]          compare_held [NUM_CH];
  logic [NUM_CH-1:0]           mask;

  logic [TIME_W-1:0]           quo;
  logic [TICK_W-1:0]           rem;
  logic [LEVEL_W-1:0]          mq;
  logic [LEVEL_W-1:0]          mr;
  logic [LEVEL_W-1:0]          val;
  logic [PROD_W-1:0]           prod;

  logic [TICK_W-1:0]           dt;
  logic [TICK_W:0]             rem_sh;
  logic                        rem_ge;
  logic [LEVEL_W:0]            mr_sh;
  logic                        mr_ge;
  logic [LEVEL_W-1:0]          cur;
  logic [LEVEL_W-1:0]          goal;
  logic [LEVEL_W-1:0]          mag;
  logic [LEVEL_W-1:0]          q;
  logic [LEVEL_W-1:0]          moved;
  logic [LEVEL_W-1:0]          ceil;
  logic [LEVEL_W-1:0]          duty_cl;
  logic [COUNT_W-1:0]          quot;
  logic [LEVEL_W-1:0]          quot_cl;

  assign dt     = (cfg.tick_ms == '0) ? TICK_W'(1) : cfg.tick_ms;
  assign rem_sh = {rem, quo[TIME_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dt};
  assign mr_sh  = {mr, mq[LEVEL_W-1]};
  assign mr_ge  = mr_sh >= {1'b0, quo[LEVEL_W-1:0]};
  assign cur    = level_now[cmd.ch];
  assign goal   = level_goal[cmd.ch];
  assign mag    = (goal > cur) ? goal - cur : cur - goal;
  assign ceil   = cfg.ceiling[cmd.ch];
  assign quot   = div255(prod);

  always_comb begin
    if (quo[TIME_W-1:LEVEL_W] != '0) begin
      q = '0;
    end else begin
      q = mq;
    end
    if (q == '0) begin
      q = LEVEL_W'(1);
    end
    if (goal > cur) begin
      moved = cur + q;
    end else if (goal < cur) begin
      moved = cur - q;
    end else begin
      moved = cur;
    end
  end

  assign duty_cl = (item.direct_duty > {{(16-LEVEL_W){1'b0}}, ceil}) ?
                   ceil : item.direct_duty[LEVEL_W-1:0];
  assign quot_cl = (quot > {{(COUNT_W-LEVEL_W){1'b0}}, ceil}) ? ceil : quot[LEVEL_W-1:0];

  assign stat.cmd       = item.cmd;
  assign stat.time_zero = (time_left == '0);
  assign stat.snap      = time_left <= {{(TIME_W-TICK_W){1'b0}}, dt};
  assign stat.direct_ch = item.direct_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        level_now[c]    <= '0;
        level_goal[c]   <= '0;
        compare_held[c] <= '0;
      end
      time_left <= '0;
    end else begin
      case (cmd.op)
        OP_START: begin
          level_goal[0] <= item.target_red;
          level_goal[1] <= item.target_green;
          level_goal[2] <= item.target_blue;
          level_goal[3] <= item.target_white;
          time_left     <= item.fade_time_ms;
        end
        OP_SNAP: begin
          for (int c = 0; c < NUM_CH; c++) begin
            level_now[c] <= level_goal[c];
          end
          time_left <= '0;
        end
        OP_MV_APPLY:  level_now[cmd.ch] <= moved;
        OP_SUB:       time_left <= time_left - {{(TIME_W-TICK_W){1'b0}}, dt};
        OP_DIV_WRITE: compare_held[cmd.ch] <= quot;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        item <= req_item;
        mask <= '0;
      end
      OP_DIV_INIT: begin
        quo <= time_left;
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= rem_ge ? TICK_W'(rem_sh - {1'b0, dt}) : rem_sh[TICK_W-1:0];
        quo <= {quo[TIME_W-2:0], rem_ge};
      end
      OP_MV_INIT: begin
        mq <= mag;
        mr <= '0;
      end
      OP_MV_STEP: begin
        mr <= mr_ge ? LEVEL_W'(mr_sh - {1'b0, quo[LEVEL_W-1:0]}) : mr_sh[LEVEL_W-1:0];
        mq <= {mq[LEVEL_W-2:0], mr_ge};
      end
      OP_SEL_LEVEL: val  <= cur;
      OP_SEL_DUTY:  val  <= duty_cl;
      OP_MUL_SQ:    prod <= PROD_W'(val) * PROD_W'(val);
      OP_DIV_SQ:    val  <= quot[LEVEL_W-1:0];
      OP_MUL_CEIL:  prod <= PROD_W'(val) * PROD_W'(ceil);
      OP_DIV_CEIL:  val  <= quot_cl;
      OP_MUL_PER:   prod <= PROD_W'(val) * PROD_W'(cfg.pwm_period);
      OP_DIV_WRITE: mask[cmd.ch] <= 1'b1;
      OP_EMIT: begin
        rsp_item.compare_red   <= compare_held[0];
        rsp_item.compare_green <= compare_held[1];
        rsp_item.compare_blue  <= compare_held[2];
        rsp_item.compare_white <= compare_held[3];
        rsp_item.updated_mask  <= mask;
        rsp_item.fading        <= (time_left != '0);
        rsp_item.remaining_ms  <= time_left;
      end
      default: ;
    endcase
  end

  a_snap_clears_time: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SNAP |=> time_left == '0)
    else $error("snap left time on the clock");

  a_direct_one_channel: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT && item.cmd == CMD_DIRECT) |=> $onehot(rsp_item.updated_mask))
    else $error("direct write item did not update exactly one channel");

  a_emit_fading: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> rsp_item.fading == (rsp_item.remaining_ms != '0))
    else $error("fading flag disagrees with remaining time");

endmodule

`default_nettype wire

### sv/rgbwf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbwf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  input  wire rgbwf_pkg::dp_stat_t stat,
  output rgbwf_pkg::dp_cmd_t  dp_cmd
);
  import rgbwf_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       ch, ch_next;
  logic             direct, direct_next;
  logic             rsp_valid_next;

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ch        <= '0;
      direct    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ch        <= ch_next;
      direct    <= direct_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ch_next        = ch;
    direct_next    = direct;
    rsp_valid_next = rsp_valid && rsp_stall;
    dp_cmd.op      = OP_NONE;
    dp_cmd.ch      = ch;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          dp_cmd.op  = OP_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_next    = '0;
        ch_next     = '0;
        direct_next = 1'b0;
        case (stat.cmd)
          CMD_START: begin
            dp_cmd.op  = OP_START;
            state_next = ST_OUT;
          end
          CMD_TICK: begin
            if (stat.time_zero) begin
              state_next = ST_OUT;
            end else if (stat.snap) begin
              dp_cmd.op  = OP_SNAP;
              state_next = ST_GAMMA;
            end else begin
              dp_cmd.op  = OP_DIV_INIT;
              state_next = ST_SDIV;
            end
          end
          CMD_DIRECT: begin
            ch_next     = stat.direct_ch;
            direct_next = 1'b1;
            state_next  = ST_DUTY;
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_SDIV: begin
        dp_cmd.op = OP_DIV_STEP;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = ST_MDIV;
        end
      end
      ST_MDIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == MV_INIT_CNT) begin
          dp_cmd.op = OP_MV_INIT;
        end else if (cnt == MV_APPLY_CNT) begin
          dp_cmd.op = OP_MV_APPLY;
          cnt_next  = '0;
          ch_next   = ch + 2'd1;
          if (ch == CH_LAST) begin
            state_next = ST_SUB;
          end
        end else begin
          dp_cmd.op = OP_MV_STEP;
        end
      end
      ST_SUB: begin
        dp_cmd.op  = OP_SUB;
        state_next = ST_GAMMA;
      end
      ST_DUTY: begin
        dp_cmd.op  = OP_SEL_DUTY;
        cnt_next   = PH_MUL_PER;
        state_next = ST_GAMMA;
      end
      ST_GAMMA: begin
        cnt_next = cnt + CNT_W'(1);
        case (cnt)
          PH_SEL:      dp_cmd.op = OP_SEL_LEVEL;
          PH_MUL_SQ:   dp_cmd.op = OP_MUL_SQ;
          PH_DIV_SQ:   dp_cmd.op = OP_DIV_SQ;
          PH_MUL_CEIL: dp_cmd.op = OP_MUL_CEIL;
          PH_DIV_CEIL: dp_cmd.op = OP_DIV_CEIL;
          PH_MUL_PER:  dp_cmd.op = OP_MUL_PER;
          PH_WRITE:    dp_cmd.op = OP_DIV_WRITE;
          default:     dp_cmd.op = OP_NONE;
        endcase
        if (cnt == PH_WRITE) begin
          cnt_next = '0;
          if (direct || ch == CH_LAST) begin
            state_next = ST_OUT;
          end else begin
            ch_next = ch + 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          dp_cmd.op      = OP_EMIT;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == ST_DECODE)
    else $error("accepted item not decoded");

  a_emit_raises_valid: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.op == OP_EMIT |=> rsp_valid)
    else $error("result register loaded without valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> dp_cmd.op != OP_EMIT)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire

### dv/rgbw_fade_gamma_pwm_tb.sv
`timescale 1ns / 1ps

module rgbw_fade_gamma_pwm_tb;
  import rgbwf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rgbw_fade_gamma_pwm u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item(req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item(rsp_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // fader shadow state and register copies
  logic [LEVEL_W-1:0] lvl_now [NUM_CH];
  logic [LEVEL_W-1:0] lvl_goal [NUM_CH];
  logic [TIME_W-1:0] remain_ms;
  logic [COUNT_W-1:0] held_cnt [NUM_CH];
  logic [LEVEL_W-1:0] cap_sh [NUM_CH];
  logic [COUNT_W-1:0] period_sh;
  logic [TICK_W-1:0] tick_sh;

  req_item_t fade_cmd_q [$];
  rsp_item_t counts_due_q [$];

  int n_queued = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_start = 0;
  int n_active_tick = 0;
  int n_direct = 0;
  int n_settings = 0;
  bit req_took = 1'b0;
  bit steady = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [COUNT_W-1:0] duty_to_count(logic [31:0] duty,
                                                       logic [LEVEL_W-1:0] cap);
    logic [31:0] d;
    d = (duty > 32'(cap)) ? 32'(cap) : duty;
    return COUNT_W'((d * 32'(period_sh)) / 32'd255);
  endfunction

  function automatic logic [COUNT_W-1:0] level_to_count(logic [LEVEL_W-1:0] x,
                                                        logic [LEVEL_W-1:0] cap);
    logic [31:0] g;
    logic [31:0] d;
    g = (32'(x) * 32'(x)) / 32'd255;
    d = (g * 32'(cap)) / 32'd255;
    return duty_to_count(d, cap);
  endfunction

  function automatic logic [LEVEL_W-1:0] move_level(logic [LEVEL_W-1:0] cur,
                                                    logic [LEVEL_W-1:0] dest,
                                                    logic [31:0] steps);
    logic [LEVEL_W-1:0] mag;
    logic [31:0] q;
    if (cur == dest) begin
      return cur;
    end
    mag = (dest > cur) ? dest - cur : cur - dest;
    q = 32'(mag) / steps;
    if (q == 0) begin
      q = 1;
    end
    return (dest > cur) ? cur + LEVEL_W'(q) : cur - LEVEL_W'(q);
  endfunction

  function automatic rsp_item_t step_fader(req_item_t it);
    rsp_item_t r;
    logic [NUM_CH-1:0] mask;
    logic [31:0] dt;
    logic [31:0] steps;
    mask = '0;
    case (it.cmd)
      CMD_START: begin
        lvl_goal[0] = it.target_red;
        lvl_goal[1] = it.target_green;
        lvl_goal[2] = it.target_blue;
        lvl_goal[3] = it.target_white;
        remain_ms = it.fade_time_ms;
        n_start++;
      end
      CMD_TICK: begin
        if (remain_ms != 0) begin
          dt = (tick_sh == 0) ? 32'd1 : 32'(tick_sh);
          if (remain_ms <= dt) begin
            for (int c = 0; c < NUM_CH; c++) lvl_now[c] = lvl_goal[c];
            remain_ms = 0;
          end else begin
            steps = remain_ms / dt;
            for (int c = 0; c < NUM_CH; c++) lvl_now[c] = move_level(lvl_now[c], lvl_goal[c], steps);
            remain_ms = remain_ms - dt;
          end
          for (int c = 0; c < NUM_CH; c++) held_cnt[c] = level_to_count(lvl_now[c], cap_sh[c]);
          mask = '1;
          n_active_tick++;
        end
      end
      CMD_DIRECT: begin
        held_cnt[it.direct_channel] = duty_to_count(32'(it.direct_duty),
                                                    cap_sh[it.direct_channel]);
        mask = NUM_CH'(1) << it.direct_channel;
        n_direct++;
      end
      default: ;
    endcase
    r.compare_red = held_cnt[0];
    r.compare_green = held_cnt[1];
    r.compare_blue = held_cnt[2];
    r.compare_white = held_cnt[3];
    r.updated_mask = mask;
    r.fading = (remain_ms != 0);
    r.remaining_ms = remain_ms;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // input side: predict on every accepted item
  always @(posedge clk) begin
    req_took <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      counts_due_q.push_back(step_fader(req_item));
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin : result_mon
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_checked++;
      if (counts_due_q.size() == 0) begin
        $error("result with no item waiting");
        n_err++;
      end else begin
        want = counts_due_q.pop_front();
        check_field("compare_red", 32'(want.compare_red), 32'(rsp_item.compare_red));
        check_field("compare_green", 32'(want.compare_green), 32'(rsp_item.compare_green));
        check_field("compare_blue", 32'(want.compare_blue), 32'(rsp_item.compare_blue));
        check_field("compare_white", 32'(want.compare_white), 32'(rsp_item.compare_white));
        check_field("updated_mask", 32'(want.updated_mask), 32'(rsp_item.updated_mask));
        check_field("fading", 32'(want.fading), 32'(rsp_item.fading));
        check_field("remaining_ms", want.remaining_ms, rsp_item.remaining_ms);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (fade_cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        req_item <= fade_cmd_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while items are still pending
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_done && n_checked >= 500 && fade_cmd_q.size() > 20) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
    end
  end

  task automatic reg_write(input logic [REG_IW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CEIL_RED: cap_sh[0] = val[LEVEL_W-1:0];
      REG_CEIL_GREEN: cap_sh[1] = val[LEVEL_W-1:0];
      REG_CEIL_BLUE: cap_sh[2] = val[LEVEL_W-1:0];
      REG_CEIL_WHITE: cap_sh[3] = val[LEVEL_W-1:0];
      REG_PWM_PERIOD: period_sh = val[COUNT_W-1:0];
      REG_TICK_MS: tick_sh = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] w, input logic [15:0] per,
                               input logic [9:0] tk);
    reg_write(REG_CEIL_RED, 32'(r));
    reg_write(REG_CEIL_GREEN, 32'(g));
    reg_write(REG_CEIL_BLUE, 32'(b));
    reg_write(REG_CEIL_WHITE, 32'(w));
    reg_write(REG_PWM_PERIOD, 32'(per));
    reg_write(REG_TICK_MS, 32'(tk));
    n_settings++;
  endtask

  task automatic queue_item(input req_item_t it);
    fade_cmd_q.push_back(it);
    n_queued++;
  endtask

  function automatic req_item_t rand_item(logic [1:0] op);
    req_item_t it;
    it.cmd = op;
    it.target_red = 8'($urandom);
    it.target_green = 8'($urandom);
    it.target_blue = 8'($urandom);
    it.target_white = 8'($urandom);
    it.fade_time_ms = $urandom;
    it.direct_channel = 2'($urandom);
    it.direct_duty = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic req_item_t mk(logic [1:0] op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] w, logic [31:0] fade, logic [1:0] ch,
                                   logic [15:0] duty);
    req_item_t it;
    it.cmd = op;
    it.target_red = r;
    it.target_green = g;
    it.target_blue = b;
    it.target_white = w;
    it.fade_time_ms = fade;
    it.direct_channel = ch;
    it.direct_duty = duty;
    return it;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (n_checked != n_queued);
  endtask

  task automatic fill_random(input int goal);
    int useful;
    int kind;
    int nt;
    int te;
    req_item_t it;
    useful = 0;
    te = (tick_sh == 0) ? 1 : int'(tick_sh);
    while (useful < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // start followed by one tick per fade step or one more, some of them replaced by direct writes
        nt = $urandom_range(1, 10);
        it = rand_item(CMD_START);
        it.fade_time_ms = te * (nt - 1) + $urandom_range(1, te);
        queue_item(it);
        useful++;
        repeat (nt + $urandom_range(0, 1)) begin
          queue_item(rand_item(($urandom_range(0, 9) == 0) ? CMD_DIRECT : CMD_TICK));
          useful++;
        end
      end else if (kind < 82) begin
        queue_item(rand_item(CMD_DIRECT));
        useful++;
      end else if (kind < 88) begin
        it = rand_item(CMD_START);
        if ($urandom_range(0, 1) == 1) begin
          it.fade_time_ms = '0;
        end
        queue_item(it);
        useful++;
      end else if (kind < 94) begin
        queue_item(rand_item(CMD_TICK));
        useful++;
      end else begin
        queue_item(rand_item(CMD_UNUSED));
      end
    end
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      lvl_now[c] = '0;
      lvl_goal[c] = '0;
      held_cnt[c] = '0;
    end
    remain_ms = '0;
    cap_sh[0] = CEIL_RED_RST;
    cap_sh[1] = CEIL_GREEN_RST;
    cap_sh[2] = CEIL_BLUE_RST;
    cap_sh[3] = CEIL_WHITE_RST;
    period_sh = PERIOD_RST;
    tick_sh = TICK_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on reset defaults
    queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, 2'd3, 16'hffff));
    queue_item(mk(CMD_DIRECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_DIRECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd1, 16'hffff));
    queue_item(mk(CMD_DIRECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd2, 16'd150));
    queue_item(mk(CMD_DIRECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd3, 16'd99));
    queue_item(mk(CMD_START, 8'd255, 8'd255, 8'd255, 8'd255, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_START, 8'd255, 8'd0, 8'd128, 8'd1, 32'd100, 2'd0, 16'd0));
    repeat (5) queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_START, 8'd0, 8'd255, 8'd0, 8'd255, 32'hffff_ffff, 2'd0, 16'd0));
    repeat (2) queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_DIRECT, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd3, 16'd200));
    queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    queue_item(mk(CMD_START, 8'd10, 8'd20, 8'd30, 8'd40, 32'd33, 2'd0, 16'd0));
    queue_item(mk(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 2'd0, 16'd0));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 16'd65535, 10'd1000);
        1: apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 10'd1);
        2: apply_setting(8'd255, 8'd0, 8'd255, 8'd0, 16'd1, 10'd0);
        4: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom), 10'd1023);
        default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom), 10'($urandom_range(1, 1000)));
      endcase
      steady = (ph == 3);
      fill_random(228);
      wait_drained();
    end
    steady = 1'b0;

    repeat (150) @(negedge clk);
    $display("checked %0d results over %0d register settings", n_checked, n_settings);
    $display("%0d starts, %0d active ticks, %0d direct writes", n_start, n_active_tick,
             n_direct);
    if (n_err == 0 && counts_due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
